/* sv/gpud_pkg.sv */
// shared types, constants and tables for the gray phase unwrap decoder
package gpud_pkg;

  localparam int GRAY_BITS       = 4;
  localparam int PHASE_FRAC_BITS = 12;
  localparam int CORDIC_STEPS    = 24;
  localparam int STEP_W          = 5;
  localparam int XY_W            = 28;
  localparam int ANG_W           = 35;
  localparam int PHASE_W         = PHASE_FRAC_BITS + 1;
  localparam int UNW_W           = 18;
  localparam int CALC_W          = 21;
  localparam int ROUND_SHIFT     = 32 - PHASE_FRAC_BITS;

  localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(64'sd2147483648);
  localparam logic signed [ANG_W-1:0] FULL_TURN = ANG_W'(64'sd4294967296);
  localparam logic signed [ANG_W-1:0] ROUND_ADD = ANG_W'(64'sd1 <<< (ROUND_SHIFT - 1));
  localparam logic signed [CALC_W-1:0] TURN     = CALC_W'(1 << PHASE_FRAC_BITS);
  localparam logic signed [CALC_W-1:0] HALF     = CALC_W'(1 << (PHASE_FRAC_BITS - 1));
  localparam logic [CALC_W-1:0] HI_LIM          = CALC_W'(8 << PHASE_FRAC_BITS);
  localparam logic [CALC_W-1:0] LO_LIM          = CALC_W'(2 << PHASE_FRAC_BITS);

  // classified pixel waiting for the back end
  typedef struct packed {
    logic [GRAY_BITS-1:0] index;
    logic signed [8:0]    dx;
    logic signed [8:0]    dy;
    logic                 frame_start;
  } item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ITER,
    B_ROUND,
    B_DONE
  } back_state_t;

  // arctangent table in units of 2^-32 turn
  function automatic logic signed [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = 32'd0;
    endcase
    return ANG_W'(a);
  endfunction

endpackage

/* sv/gpud_if.sv */
// pixel and result channel interfaces
interface gpud_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] gray_samples;
  logic [7:0]  phase_sample_0;
  logic [7:0]  phase_sample_1;
  logic [7:0]  phase_sample_2;
  logic [7:0]  phase_sample_3;
  logic        frame_start;
  modport source (output valid, gray_samples, phase_sample_0, phase_sample_1,
                  phase_sample_2, phase_sample_3, frame_start, input ready);
  modport sink (input valid, gray_samples, phase_sample_0, phase_sample_1,
                phase_sample_2, phase_sample_3, frame_start, output ready);
endinterface

interface gpud_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         period_index;
  logic [12:0]        wrapped_phase;
  logic signed [17:0] unwrapped_phase;
  modport source (output valid, period_index, wrapped_phase, unwrapped_phase,
                  input ready);
  modport sink (input valid, period_index, wrapped_phase, unwrapped_phase,
                output ready);
endinterface

/* sv/gpud_front.sv */
// front end: threshold register, gray bit slicing, gray to binary, phase differences
module gpud_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [7:0]     cfg_wr_data,
  gpud_in_if.sink        in_ch,
  input  logic           q_full,
  output logic           push,
  output gpud_pkg::item_t push_item
);

  logic [7:0] threshold;
  logic [gpud_pkg::GRAY_BITS-1:0] gray;
  logic [gpud_pkg::GRAY_BITS-1:0] bin;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 8'd240;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  // gray bits, image 0 most significant
  always_comb begin
    for (int i = 0; i < gpud_pkg::GRAY_BITS; i++) begin
      if (8 * (gpud_pkg::GRAY_BITS - 1 - i) + 7 <= 31) begin
        gray[gpud_pkg::GRAY_BITS-1-i] =
          (in_ch.gray_samples[8*(gpud_pkg::GRAY_BITS-1-i) +: 8] > threshold);
      end else begin
        gray[gpud_pkg::GRAY_BITS-1-i] = 1'b0;
      end
    end
    bin[gpud_pkg::GRAY_BITS-1] = gray[gpud_pkg::GRAY_BITS-1];
    for (int i = gpud_pkg::GRAY_BITS - 2; i >= 0; i--) begin
      bin[i] = gray[i] ^ bin[i+1];
    end
  end

  // hand the classified pixel to the queue
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  always_comb begin
    push_item.index       = bin;
    push_item.dx          = $signed({1'b0, in_ch.phase_sample_2}) -
                            $signed({1'b0, in_ch.phase_sample_0});
    push_item.dy          = $signed({1'b0, in_ch.phase_sample_1}) -
                            $signed({1'b0, in_ch.phase_sample_3});
    push_item.frame_start = in_ch.frame_start;
  end

endmodule

/* sv/gpud_queue.sv */
// two-entry queue between front and back ends
module gpud_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gpud_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output gpud_pkg::item_t head
);

  gpud_pkg::item_t store [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = store[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* sv/gpud_back.sv */
// back end: iterative cordic, rounding, period edge correction, output register
module gpud_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  gpud_pkg::item_t head,
  output logic            pop,
  gpud_out_if.source      out_ch
);

  gpud_pkg::back_state_t state, state_next;
  gpud_pkg::item_t item;
  logic signed [gpud_pkg::XY_W-1:0]  x, y;
  logic signed [gpud_pkg::ANG_W-1:0] ang;
  logic [gpud_pkg::STEP_W-1:0]       step;
  logic [gpud_pkg::PHASE_W-1:0]      w;
  logic signed [gpud_pkg::UNW_W-1:0] prev;
  logic out_valid;

  logic signed [gpud_pkg::XY_W-1:0]  lx, ly, xs, ys;
  logic signed [gpud_pkg::ANG_W-1:0] p;
  logic signed [gpud_pkg::ANG_W-1:0] pr;
  logic signed [gpud_pkg::CALC_W-1:0] val, prv, diff, w10;
  logic out_free;

  assign out_free = !out_valid || out_ch.ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gpud_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and queue pop
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      gpud_pkg::B_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = gpud_pkg::B_ITER;
        end
      end
      gpud_pkg::B_ITER: begin
        if (step == 5'(gpud_pkg::CORDIC_STEPS - 1)) state_next = gpud_pkg::B_ROUND;
      end
      gpud_pkg::B_ROUND: state_next = gpud_pkg::B_DONE;
      gpud_pkg::B_DONE: begin
        if (out_free) state_next = gpud_pkg::B_IDLE;
      end
      default: state_next = gpud_pkg::B_IDLE;
    endcase
  end

  // cordic load values and one rotation step
  always_comb begin
    lx = gpud_pkg::XY_W'(head.dx) <<< 16;
    ly = gpud_pkg::XY_W'(head.dy) <<< 16;
    xs = x >>> step;
    ys = y >>> step;
  end

  // rounding to the output phase grid
  always_comb begin
    if (item.dx == 9'sd0 && item.dy == 9'sd0) p = gpud_pkg::HALF_TURN;
    else p = ang + gpud_pkg::HALF_TURN;
    if (p < 0) p = '0;
    if (p > gpud_pkg::FULL_TURN) p = gpud_pkg::FULL_TURN;
    pr = (p + gpud_pkg::ROUND_ADD) >>> gpud_pkg::ROUND_SHIFT;
  end

  // unwrap against the previous output
  always_comb begin
    prv  = item.frame_start ? '0 : gpud_pkg::CALC_W'(prev);
    val  = (gpud_pkg::CALC_W'(item.index) <<< gpud_pkg::PHASE_FRAC_BITS) +
           gpud_pkg::CALC_W'(w);
    diff = val - prv;
    w10  = gpud_pkg::CALC_W'(w) * gpud_pkg::CALC_W'(10);
    if ($unsigned(w10) > gpud_pkg::HI_LIM && diff > gpud_pkg::HALF) begin
      val = val - gpud_pkg::TURN;
    end else if ($unsigned(w10) < gpud_pkg::LO_LIM && diff < -gpud_pkg::HALF) begin
      val = val + gpud_pkg::TURN;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      gpud_pkg::B_IDLE: begin
        item <= head;
        step <= '0;
        if (lx < 0) begin
          x   <= -lx;
          y   <= -ly;
          ang <= (ly >= 0) ? gpud_pkg::HALF_TURN : -gpud_pkg::HALF_TURN;
        end else begin
          x   <= lx;
          y   <= ly;
          ang <= '0;
        end
      end
      gpud_pkg::B_ITER: begin
        step <= step + 5'd1;
        if (y > 0) begin
          x   <= x + ys;
          y   <= y - xs;
          ang <= ang + gpud_pkg::atan_step(step);
        end else begin
          x   <= x - ys;
          y   <= y + xs;
          ang <= ang - gpud_pkg::atan_step(step);
        end
      end
      gpud_pkg::B_ROUND: w <= gpud_pkg::PHASE_W'(pr);
      default: ;
    endcase
  end

  // result register and stored previous output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      prev      <= '0;
    end else begin
      if (state == gpud_pkg::B_DONE && out_free) begin
        out_valid              <= 1'b1;
        prev                   <= gpud_pkg::UNW_W'(val);
        out_ch.period_index    <= 4'(item.index);
        out_ch.wrapped_phase   <= w;
        out_ch.unwrapped_phase <= gpud_pkg::UNW_W'(val);
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid;

endmodule

/* sv/gray_phase_unwrap_decoder_unit.sv */
// top level of the gray code and phase shift unwrap decoder
// Usage:
//   in_ch carries one pixel per transfer: packed gray bytes, four phase
//   shift intensities and a frame start flag. out_ch carries the period
//   index, the wrapped phase and the unwrapped absolute phase.
//   cfg_wr_en / cfg_wr_data write the brightness threshold (reset 240);
//   write it only while no pixel is in flight.
// Timing:
//   the front end classifies a pixel in the cycle of its transfer and drops
//   it in a two-entry queue. The back end pops and loads it while idle,
//   runs a 24-step cordic, one step a cycle, then rounds and, once the
//   output register is free, unwraps into it. The shared cordic takes no
//   new pixel until the last one has reached the output register.
// Reset and stalls:
//   rst clears the queue, the back end, the stored previous output and sets
//   the threshold to 240. When the receiver stalls, the result waits in the
//   output register and the back end holds; the queue keeps taking pixels
//   until full.
module gray_phase_unwrap_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  gpud_in_if.sink    in_ch,
  gpud_out_if.source out_ch
);

  gpud_pkg::item_t push_item;
  gpud_pkg::item_t head;
  logic push, pop, q_full, q_empty;

  gpud_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  gpud_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  gpud_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

/* dv/gpud_checker.sv */
// result checker for the gray phase unwrap decoder: predicts and compares
`timescale 1ns / 1ps
module gpud_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  gpud_in_if.sink    in_mon,
  gpud_out_if.sink   out_mon,
  output int         fail_count,
  output int         pending
);

  typedef struct {
    logic [3:0]         period_index;
    logic [12:0]        wrapped_phase;
    logic signed [17:0] unwrapped_phase;
  } pixel_result_t;

  pixel_result_t expected_q[$];
  logic [7:0]         threshold;
  logic signed [17:0] last_unwrapped;

  // floor shift of a signed 64-bit value
  function automatic longint asr(input longint v, input int s);
    return v >>> s;
  endfunction

  // cordic phase in turn/4096, zero vector gives half a turn
  function automatic int cordic_phase(input longint dx, input longint dy);
    longint x, y, ang, p, xs, ys;
    x = dx * 65536;
    y = dy * 65536;
    ang = 0;
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        ang = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < gpud_pkg::CORDIC_STEPS; i++) begin
        xs = asr(x, i);
        ys = asr(y, i);
        if (y > 0) begin
          x += ys; y -= xs;
          ang += longint'(gpud_pkg::atan_step(gpud_pkg::STEP_W'(i)));
        end else begin
          x -= ys; y += xs;
          ang -= longint'(gpud_pkg::atan_step(gpud_pkg::STEP_W'(i)));
        end
      end
    end
    p = ang + 64'sd2147483648;
    if (p < 0) p = 0;
    if (p > 64'sd4294967296) p = 64'sd4294967296;
    p = (p + (64'sd1 <<< (31 - gpud_pkg::PHASE_FRAC_BITS))) >>>
        (32 - gpud_pkg::PHASE_FRAC_BITS);
    if (p > (64'sd1 <<< gpud_pkg::PHASE_FRAC_BITS)) p = 64'sd1 <<< gpud_pkg::PHASE_FRAC_BITS;
    return int'(p);
  endfunction

  // predict one pixel transfer
  task automatic predict_pixel();
    logic [gpud_pkg::GRAY_BITS-1:0] gray, bin;
    longint turn, w, val, diff, prev;
    pixel_result_t r;
    turn = 64'sd1 <<< gpud_pkg::PHASE_FRAC_BITS;
    if (in_mon.frame_start) last_unwrapped = '0;
    for (int i = 0; i < gpud_pkg::GRAY_BITS; i++)
      gray[gpud_pkg::GRAY_BITS-1-i] =
        in_mon.gray_samples[8*(gpud_pkg::GRAY_BITS-1-i) +: 8] > threshold;
    bin[gpud_pkg::GRAY_BITS-1] = gray[gpud_pkg::GRAY_BITS-1];
    for (int i = gpud_pkg::GRAY_BITS - 2; i >= 0; i--) bin[i] = gray[i] ^ bin[i+1];
    w = cordic_phase(longint'(in_mon.phase_sample_2) - longint'(in_mon.phase_sample_0),
                     longint'(in_mon.phase_sample_1) - longint'(in_mon.phase_sample_3));
    prev = longint'(last_unwrapped);
    val = longint'(bin) * turn + w;
    diff = val - prev;
    if (w * 10 > 8 * turn && diff > turn / 2) val -= turn;
    else if (w * 10 < 2 * turn && diff < -(turn / 2)) val += turn;
    last_unwrapped = val[17:0];
    r.period_index = 4'(bin);
    r.wrapped_phase = w[12:0];
    r.unwrapped_phase = last_unwrapped;
    expected_q = {expected_q, r};
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    pixel_result_t e;
    int errs;
    errs = 0;
    if (rst) begin
      threshold <= 8'd240;
      last_unwrapped = '0;
      expected_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_wr_en) threshold <= cfg_wr_data;
      if (in_mon.valid && in_mon.ready) predict_pixel();
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errs = errs + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_mon.period_index !== e.period_index) begin
            $error("period_index expected %0d actual %0d", e.period_index,
                   out_mon.period_index);
            errs = errs + 1;
          end
          if (out_mon.wrapped_phase !== e.wrapped_phase) begin
            $error("wrapped_phase expected %0d actual %0d", e.wrapped_phase,
                   out_mon.wrapped_phase);
            errs = errs + 1;
          end
          if (out_mon.unwrapped_phase !== e.unwrapped_phase) begin
            $error("unwrapped_phase expected %0d actual %0d", e.unwrapped_phase,
                   out_mon.unwrapped_phase);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= expected_q.size();
    end
  end

endmodule

/* dv/tb.sv */
// stimulus and verdict for the gray phase unwrap decoder
`timescale 1ns / 1ps
module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;
  int fail_count;
  int pending;
  int send_idle = 0;
  int recv_idle = 0;
  logic [7:0] thr_set[4] = '{8'd0, 8'd255, 8'd128, 8'd240};

  gpud_in_if in_ch ();
  gpud_out_if out_ch ();

  gray_phase_unwrap_decoder_unit uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  gpud_checker chk (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_mon(in_ch), .out_mon(out_ch), .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random
  initial out_ch.ready = 1'b0;
  always @(negedge clk)
    out_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle);

  // put one pixel on the channel and wait for its transfer
  task automatic send_pixel(input logic [31:0] g, input logic [7:0] p0, p1, p2, p3,
                            input logic fs);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.gray_samples <= g;
    in_ch.phase_sample_0 <= p0;
    in_ch.phase_sample_1 <= p1;
    in_ch.phase_sample_2 <= p2;
    in_ch.phase_sample_3 <= p3;
    in_ch.frame_start <= fs;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // wait till idle, then write the threshold
  task automatic set_threshold(input logic [7:0] v);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // random pixel: mostly smooth fringes within a frame
  task automatic random_pixel(input int n);
    logic [31:0] g;
    int ang, amp;
    g = $urandom();
    if ($urandom_range(3) != 0) begin
      for (int b = 0; b < 4; b++) g[8*b +: 8] = $urandom_range(1) ? 8'd255 : 8'd0;
      amp = $urandom_range(127);
      ang = $urandom_range(3);
      send_pixel(g, 8'(128 - (ang == 0 ? amp : 0)), 8'(128 + (ang == 1 ? amp : 0)),
                 8'(128 + (ang == 2 ? amp : 0)), 8'(128 - (ang == 3 ? amp : 0)),
                 (n % 64) == 0);
    end else
      send_pixel(g, 8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                 $urandom_range(15) == 0);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.gray_samples = '0;
    in_ch.phase_sample_0 = '0;
    in_ch.phase_sample_1 = '0;
    in_ch.phase_sample_2 = '0;
    in_ch.phase_sample_3 = '0;
    in_ch.frame_start = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes, zero vector, axes, edge corrections
    send_pixel(32'h0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(32'hFFFFFFFF, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(32'hF1F0F1F0, 8'd0, 8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(32'h0, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(32'h0, 8'd255, 8'd0, 8'd0, 8'd1, 1'b0);
    send_pixel(32'h0, 8'd255, 8'd1, 8'd0, 8'd0, 1'b0);
    send_pixel(32'h0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(32'h0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(32'hFF000000, 8'd100, 8'd90, 8'd100, 8'd110, 1'b1);
    send_pixel(32'hFF00FF00, 8'd100, 8'd110, 8'd100, 8'd90, 1'b0);
    send_pixel(32'hFFFFFFFF, 8'd110, 8'd100, 8'd90, 8'd101, 1'b0);
    send_pixel(32'h00FFFFFF, 8'd110, 8'd100, 8'd90, 8'd99, 1'b0);
    send_pixel(32'h0000FFFF, 8'd90, 8'd100, 8'd110, 8'd101, 1'b0);
    send_pixel(32'h000000FF, 8'd110, 8'd99, 8'd90, 8'd100, 1'b1);
    send_pixel(32'h00FF0000, 8'd200, 8'd5, 8'd40, 8'd6, 1'b0);
    send_pixel(32'hAA55AA55, 8'd3, 8'd77, 8'd250, 8'd12, 1'b0);

    // random part over thresholds and idling modes
    for (int ph = 0; ph < 4; ph++) begin
      set_threshold(thr_set[ph]);
      send_idle = (ph == 0) ? 15 : (ph == 1) ? 62 : 0;
      recv_idle = (ph == 0) ? 62 : (ph == 1) ? 15 : 0;
      for (int n = 0; n < 210; n++) random_pixel(n);
    end
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) $display("gray_phase_unwrap_decoder_unit test passed");
    else $display("gray_phase_unwrap_decoder_unit test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("gray_phase_unwrap_decoder_unit test failed");
    $finish;
  end

endmodule

/* sim.f */
sv/gpud_pkg.sv
sv/gpud_if.sv
sv/gpud_front.sv
sv/gpud_queue.sv
sv/gpud_back.sv
sv/gray_phase_unwrap_decoder_unit.sv
dv/gpud_checker.sv
dv/tb.sv
